// File: hw/rtl/lsw_pkg.sv
package lsw_pkg;

    localparam int CELL_W     = 16;
    localparam int LIMIT_W    = 32;
    localparam int SIDE_REG_W = 7;
    localparam int OUT_W      = 7;
    localparam int REG_IDX_W  = 1;
    localparam int DATA_W     = 32;
    localparam int PHASE_W    = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SUM_LIMIT = 1'b0,
        REG_GRID_SIDE = 1'b1
    } lsw_reg_idx_t;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_MID  = 3'b010,
        ST_WIN  = 3'b100
    } lsw_state_t;

    // corner terms of one window sum, in issue order
    localparam logic [1:0] TERM_BR   = 2'd0;
    localparam logic [1:0] TERM_UP   = 2'd1;
    localparam logic [1:0] TERM_LEFT = 2'd2;
    localparam logic [1:0] TERM_DIAG = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_ISSUE = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd4;

endpackage

// File: hw/rtl/lsw_ram.sv
module lsw_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/largest_square_window_under_limit.sv
// Cells of an n-by-n grid enter in row-major order, one word per cycle while busy is low;
// each cell adds one entry to a prefix-sum RAM. After the last cell, busy rises and a
// binary search over sides 0..n runs; each tested side scans every window, stopping early
// at one whose sum exceeds the limit, one corner read per cycle on the single RAM read
// port; the search tests about log2(n+2) sides. The answer appears on largest_side, which
// holds it afterwards, with done high for exactly one cycle; busy falls in that same cycle.
// The receiver cannot stall the result; capture it when done is high. Write registers only
// while busy is low; a grid_side write drops any partial grid. No clearing pass after reset.
module largest_square_window_under_limit #(
    parameter int MAX_SIDE   = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lsw_pkg::CELL_W-1:0]      cell_value,
    input  logic                            wr_en,
    input  logic [lsw_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [lsw_pkg::DATA_W-1:0]      wr_data,
    output logic                            done,
    output logic [lsw_pkg::OUT_W-1:0]       largest_side
);

    import lsw_pkg::*;

    localparam int VAL_W   = (VALUE_BITS < CELL_W) ? VALUE_BITS : CELL_W;
    localparam int IDX_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int LH_W    = SIDE_W + 1;
    localparam int RS_W    = VAL_W + IDX_W;
    localparam int PRE_W   = VAL_W + 2 * IDX_W;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int CMP_W   = (PRE_W > LIMIT_W) ? PRE_W : LIMIT_W;
    localparam int EXT_W   = (SIDE_W > SIDE_REG_W) ? SIDE_W : SIDE_REG_W;

    lsw_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    ld_row_reg, ld_row_next;
    logic [IDX_W-1:0]    ld_col_reg, ld_col_next;
    logic [RS_W-1:0]     row_sum_reg, row_sum_next;
    logic [LIMIT_W-1:0]  sum_limit_reg, sum_limit_next;
    logic [SIDE_REG_W-1:0] grid_side_reg, grid_side_next;
    logic [LH_W-1:0]     lo_reg, lo_next;
    logic [LH_W-1:0]     hi_reg, hi_next;
    logic [SIDE_W-1:0]   best_reg, best_next;
    logic [SIDE_W-1:0]   side_reg, side_next;
    logic [IDX_W-1:0]    sr_row_reg, sr_row_next;
    logic [IDX_W-1:0]    sr_col_reg, sr_col_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                term_valid_reg, term_valid_next;
    logic                term_neg_reg, term_neg_next;
    logic [PRE_W-1:0]    acc_reg, acc_next;
    logic                done_reg, done_next;
    logic [OUT_W-1:0]    largest_reg, largest_next;

    logic                accept;
    logic [EXT_W-1:0]    gs_ext;
    logic [SIDE_W-1:0]   side_use;
    logic [SIDE_W-1:0]   side_last;
    logic [VAL_W-1:0]    cell_v;
    logic [RS_W-1:0]     rs_new;
    logic [PRE_W-1:0]    above;
    logic [PRE_W-1:0]    prefix;
    logic                ld_row_end, ld_col_end;
    logic [ADDR_W-1:0]   raddr;
    logic [ADDR_W-1:0]   load_raddr;
    logic [IDX_W-1:0]    ld_row_up;
    logic [PRE_W-1:0]    rdata;
    logic [LH_W:0]       lh_sum;
    logic [SIDE_W-1:0]   mid;
    logic [SIDE_W-1:0]   sr_row_ext, sr_col_ext;
    logic                row_up_ok, col_up_ok;
    logic [IDX_W-1:0]    row_up, col_up;
    logic [IDX_W-1:0]    t_row, t_col;
    logic                t_valid, t_neg;
    logic [PRE_W-1:0]    term_val;
    logic [PRE_W-1:0]    add_a;
    logic [PRE_W-1:0]    add_out;
    logic                win_fail;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_LOAD);
    assign done   = done_reg;
    assign largest_side = largest_reg;

    assign gs_ext = EXT_W'(grid_side_reg);

    always_comb
    begin
        if (gs_ext == '0)
        begin
            side_use = SIDE_W'(1);
        end
        else if (gs_ext > EXT_W'(MAX_SIDE))
        begin
            side_use = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_use = SIDE_W'(gs_ext);
        end
    end

    assign side_last = side_use - SIDE_W'(1);

    assign cell_v = cell_value[VAL_W-1:0];
    assign rs_new = ((ld_col_reg == '0) ? '0 : row_sum_reg) + RS_W'(cell_v);
    assign above  = (ld_row_reg == '0) ? '0 : rdata;
    assign prefix = above + PRE_W'(rs_new);

    assign ld_col_end = (SIDE_W'(ld_col_reg) == side_last);
    assign ld_row_end = (SIDE_W'(ld_row_reg) == side_last);

    assign ld_row_up  = ld_row_next - IDX_W'(1);
    assign load_raddr = {ld_row_up, ld_col_next};

    assign lh_sum = (LH_W+1)'(lo_reg) + (LH_W+1)'(hi_reg);
    assign mid    = SIDE_W'(lh_sum >> 1);

    assign sr_row_ext = SIDE_W'(sr_row_reg);
    assign sr_col_ext = SIDE_W'(sr_col_reg);
    assign row_up_ok  = (sr_row_ext >= side_reg);
    assign col_up_ok  = (sr_col_ext >= side_reg);
    assign row_up     = IDX_W'(sr_row_ext - side_reg);
    assign col_up     = IDX_W'(sr_col_ext - side_reg);

    always_comb
    begin
        case (phase_reg[1:0])
            TERM_BR:
            begin
                t_row = sr_row_reg;
                t_col = sr_col_reg;
                t_valid = 1'b1;
                t_neg = 1'b0;
            end
            TERM_UP:
            begin
                t_row = row_up;
                t_col = sr_col_reg;
                t_valid = row_up_ok;
                t_neg = 1'b1;
            end
            TERM_LEFT:
            begin
                t_row = sr_row_reg;
                t_col = col_up;
                t_valid = col_up_ok;
                t_neg = 1'b1;
            end
            default:
            begin
                t_row = row_up;
                t_col = col_up;
                t_valid = row_up_ok && col_up_ok;
                t_neg = 1'b0;
            end
        endcase
    end

    assign raddr = (state_reg == ST_WIN) ? {t_row, t_col} : load_raddr;

    // shared add/subtract unit for the window sum
    assign term_val = term_valid_reg ? rdata : '0;
    assign add_a    = (phase_reg == PHASE_FIRST) ? '0 : acc_reg;
    assign add_out  = term_neg_reg ? (add_a - term_val) : (add_a + term_val);
    assign win_fail = (CMP_W'(add_out) > CMP_W'(sum_limit_reg));

    always_comb
    begin
        state_next      = state_reg;
        ld_row_next     = ld_row_reg;
        ld_col_next     = ld_col_reg;
        row_sum_next    = row_sum_reg;
        sum_limit_next  = sum_limit_reg;
        grid_side_next  = grid_side_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        best_next       = best_reg;
        side_next       = side_reg;
        sr_row_next     = sr_row_reg;
        sr_col_next     = sr_col_reg;
        phase_next      = phase_reg;
        term_valid_next = term_valid_reg;
        term_neg_next   = term_neg_reg;
        acc_next        = acc_reg;
        done_next       = 1'b0;
        largest_next    = largest_reg;

        if (wr_en)
        begin
            unique case (lsw_reg_idx_t'(wr_index))
                REG_SUM_LIMIT:
                begin
                    sum_limit_next = wr_data[LIMIT_W-1:0];
                end
                REG_GRID_SIDE:
                begin
                    grid_side_next = wr_data[SIDE_REG_W-1:0];
                    ld_row_next    = '0;
                    ld_col_next    = '0;
                    row_sum_next   = '0;
                end
                default:
                begin
                    sum_limit_next = sum_limit_reg;
                end
            endcase
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    row_sum_next = rs_new;
                    if (ld_col_end)
                    begin
                        ld_col_next = '0;
                        if (ld_row_end)
                        begin
                            ld_row_next  = '0;
                            row_sum_next = '0;
                            lo_next      = '0;
                            hi_next      = LH_W'(side_use);
                            best_next    = '0;
                            state_next   = ST_MID;
                        end
                        else
                        begin
                            ld_row_next = ld_row_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        ld_col_next = ld_col_reg + IDX_W'(1);
                    end
                end
            end
            ST_MID:
            begin
                if (lo_reg > hi_reg)
                begin
                    done_next    = 1'b1;
                    largest_next = OUT_W'(best_reg);
                    state_next   = ST_LOAD;
                end
                else if (mid == '0)
                begin
                    best_next = '0;
                    lo_next   = LH_W'(1);
                end
                else
                begin
                    side_next   = mid;
                    sr_row_next = IDX_W'(mid - SIDE_W'(1));
                    sr_col_next = IDX_W'(mid - SIDE_W'(1));
                    phase_next  = PHASE_ISSUE;
                    state_next  = ST_WIN;
                end
            end
            ST_WIN:
            begin
                term_valid_next = t_valid;
                term_neg_next   = t_neg;
                if (phase_reg != PHASE_ISSUE)
                begin
                    acc_next = add_out;
                end
                if (phase_reg == PHASE_LAST)
                begin
                    phase_next = PHASE_ISSUE;
                    if (win_fail)
                    begin
                        hi_next    = LH_W'(side_reg) - LH_W'(1);
                        state_next = ST_MID;
                    end
                    else if (sr_col_ext == side_last)
                    begin
                        sr_col_next = IDX_W'(side_reg - SIDE_W'(1));
                        if (sr_row_ext == side_last)
                        begin
                            best_next  = side_reg;
                            lo_next    = LH_W'(side_reg) + LH_W'(1);
                            state_next = ST_MID;
                        end
                        else
                        begin
                            sr_row_next = sr_row_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        sr_col_next = sr_col_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            ld_row_reg     <= '0;
            ld_col_reg     <= '0;
            row_sum_reg    <= '0;
            sum_limit_reg  <= '0;
            grid_side_reg  <= SIDE_REG_W'(1);
            lo_reg         <= '0;
            hi_reg         <= '0;
            best_reg       <= '0;
            side_reg       <= '0;
            sr_row_reg     <= '0;
            sr_col_reg     <= '0;
            phase_reg      <= PHASE_ISSUE;
            term_valid_reg <= 1'b0;
            term_neg_reg   <= 1'b0;
            acc_reg        <= '0;
            done_reg       <= 1'b0;
            largest_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ld_row_reg     <= ld_row_next;
            ld_col_reg     <= ld_col_next;
            row_sum_reg    <= row_sum_next;
            sum_limit_reg  <= sum_limit_next;
            grid_side_reg  <= grid_side_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            best_reg       <= best_next;
            side_reg       <= side_next;
            sr_row_reg     <= sr_row_next;
            sr_col_reg     <= sr_col_next;
            phase_reg      <= phase_next;
            term_valid_reg <= term_valid_next;
            term_neg_reg   <= term_neg_next;
            acc_reg        <= acc_next;
            done_reg       <= done_next;
            largest_reg    <= largest_next;
        end
    end

    lsw_ram #(
        .WIDTH (PRE_W),
        .DEPTH (DEPTH)
    ) u_prefix_ram (
        .clk   (clk),
        .we    (accept),
        .waddr ({ld_row_reg, ld_col_reg}),
        .wdata (prefix),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule
